### src/kbsc_pkg.sv
`default_nettype none

package kbsc_pkg;

   localparam int TABLE_ENTRIES = 128;

   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [7:0] PAD_PREFIX  = 8'h79;
   localparam logic [7:0] SHIFT_MAKE  = 8'h71;
   localparam logic [7:0] SHIFT_BREAK = 8'hf1;

   localparam logic [1:0] ACTION_RELEASE = 2'd0;
   localparam logic [1:0] ACTION_REPEAT  = 2'd2;

   localparam logic [7:0] CODE_CAPS      = 8'd58;
   localparam logic [7:0] CODE_PAD_STAR  = 8'd55;
   localparam logic [7:0] CODE_PAD_PLUS  = 8'd78;
   localparam logic [7:0] CODE_PAD_SLASH = 8'd98;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_PAD,
      KIND_SHIFT
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic       press;
      logic [7:0] scan;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_pad_key(input logic [7:0] c);
      is_pad_key = (c == 8'd69) || (c >= 8'd71 && c <= 8'd77) ||
                   (c >= 8'd79 && c <= 8'd83) || (c == 8'd96) ||
                   (c == 8'd103) || (c == 8'd105) || (c == 8'd106) ||
                   (c == 8'd108);
   endfunction

   // bit 8 valid, bits 7..0 scan code
   function automatic logic [8:0] rom_lookup(input logic [6:0] idx);
      rom_lookup = 9'd0;
      case (idx)
         7'd2:   rom_lookup = 9'h125;  7'd3:   rom_lookup = 9'h127;
         7'd4:   rom_lookup = 9'h129;  7'd5:   rom_lookup = 9'h12b;
         7'd6:   rom_lookup = 9'h12f;  7'd7:   rom_lookup = 9'h12d;
         7'd8:   rom_lookup = 9'h135;  7'd9:   rom_lookup = 9'h139;
         7'd10:  rom_lookup = 9'h133;  7'd11:  rom_lookup = 9'h13b;
         7'd12:  rom_lookup = 9'h137;  7'd13:  rom_lookup = 9'h131;
         7'd14:  rom_lookup = 9'h167;  7'd15:  rom_lookup = 9'h161;
         7'd16:  rom_lookup = 9'h119;  7'd17:  rom_lookup = 9'h11b;
         7'd18:  rom_lookup = 9'h11d;  7'd19:  rom_lookup = 9'h11f;
         7'd20:  rom_lookup = 9'h123;  7'd21:  rom_lookup = 9'h121;
         7'd22:  rom_lookup = 9'h141;  7'd23:  rom_lookup = 9'h145;
         7'd24:  rom_lookup = 9'h13f;  7'd25:  rom_lookup = 9'h147;
         7'd26:  rom_lookup = 9'h143;  7'd27:  rom_lookup = 9'h13d;
         7'd28:  rom_lookup = 9'h149;  7'd29:  rom_lookup = 9'h175;
         7'd30:  rom_lookup = 9'h101;  7'd31:  rom_lookup = 9'h103;
         7'd32:  rom_lookup = 9'h105;  7'd33:  rom_lookup = 9'h107;
         7'd34:  rom_lookup = 9'h10b;  7'd35:  rom_lookup = 9'h109;
         7'd36:  rom_lookup = 9'h14d;  7'd37:  rom_lookup = 9'h151;
         7'd38:  rom_lookup = 9'h14b;  7'd39:  rom_lookup = 9'h153;
         7'd40:  rom_lookup = 9'h14f;  7'd41:  rom_lookup = 9'h165;
         7'd42:  rom_lookup = 9'h171;  7'd43:  rom_lookup = 9'h155;
         7'd44:  rom_lookup = 9'h10d;  7'd45:  rom_lookup = 9'h10f;
         7'd46:  rom_lookup = 9'h111;  7'd47:  rom_lookup = 9'h113;
         7'd48:  rom_lookup = 9'h117;  7'd49:  rom_lookup = 9'h15b;
         7'd50:  rom_lookup = 9'h15d;  7'd51:  rom_lookup = 9'h157;
         7'd52:  rom_lookup = 9'h15f;  7'd53:  rom_lookup = 9'h159;
         7'd54:  rom_lookup = 9'h171;  7'd55:  rom_lookup = 9'h105;
         7'd56:  rom_lookup = 9'h16f;  7'd57:  rom_lookup = 9'h163;
         7'd58:  rom_lookup = 9'h173;
         7'd69:  rom_lookup = 9'h10f;  7'd71:  rom_lookup = 9'h133;
         7'd72:  rom_lookup = 9'h137;  7'd73:  rom_lookup = 9'h139;
         7'd74:  rom_lookup = 9'h11d;  7'd75:  rom_lookup = 9'h12d;
         7'd76:  rom_lookup = 9'h12f;  7'd77:  rom_lookup = 9'h131;
         7'd78:  rom_lookup = 9'h10d;  7'd79:  rom_lookup = 9'h127;
         7'd80:  rom_lookup = 9'h129;  7'd81:  rom_lookup = 9'h12b;
         7'd82:  rom_lookup = 9'h125;  7'd83:  rom_lookup = 9'h103;
         7'd86:  rom_lookup = 9'h155;
         7'd96:  rom_lookup = 9'h119;  7'd97:  rom_lookup = 9'h175;
         7'd98:  rom_lookup = 9'h11b;  7'd100: rom_lookup = 9'h16f;
         7'd103: rom_lookup = 9'h11b;  7'd105: rom_lookup = 9'h10d;
         7'd106: rom_lookup = 9'h105;  7'd108: rom_lookup = 9'h111;
         7'd125: rom_lookup = 9'h16f;  7'd126: rom_lookup = 9'h16f;
         7'd127: rom_lookup = 9'h16f;
         default: rom_lookup = 9'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

### src/kbsc_front.sv
`default_nettype none

module kbsc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   input  wire  [7:0]             req_key_code,
   input  wire  [1:0]             req_key_action,
   input  kbsc_pkg::q_status_type q_status,
   output logic                   q_push,
   output kbsc_pkg::entry_type    q_entry
);
   import kbsc_pkg::*;

   logic       caps_ff, caps_in;
   logic [8:0] rom_word;
   logic       in_range, hit, press, accept, is_caps;
   logic [7:0] sc;

   always_comb begin
      rom_word = rom_lookup(req_key_code[6:0]);
      in_range = !req_key_code[7] && ({1'b0, req_key_code} < 9'(TABLE_ENTRIES));
      hit      = in_range && rom_word[8] && (req_key_action != ACTION_REPEAT);
      press    = (req_key_action != ACTION_RELEASE);
      sc       = rom_word[7:0];
      is_caps  = (req_key_code == CODE_CAPS);
      accept   = req_push && !q_status.full;

      caps_in       = caps_ff;
      q_entry.press = press;
      q_entry.scan  = press ? sc : (sc | RELEASE_BIT);
      q_entry.kind  = KIND_SINGLE;
      q_push        = accept && hit;

      if (is_caps) begin
         q_push = accept && hit && press;
         q_entry.scan = !caps_ff ? sc : (sc | RELEASE_BIT);
         if (accept && hit && press) begin
            caps_in = !caps_ff;
         end
      end else if (req_key_code == CODE_PAD_STAR || req_key_code == CODE_PAD_PLUS ||
                   req_key_code == CODE_PAD_SLASH) begin
         q_entry.kind = KIND_SHIFT;
      end else if (is_pad_key(req_key_code)) begin
         q_entry.kind = KIND_PAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caps_ff <= 1'b0;
      end else begin
         caps_ff <= caps_in;
      end
   end

endmodule

`default_nettype wire

### src/kbsc_queue.sv
`default_nettype none

module kbsc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  kbsc_pkg::entry_type    push_entry,
   input  wire                    pop,
   output kbsc_pkg::entry_type    head,
   output kbsc_pkg::q_status_type status
);
   import kbsc_pkg::*;

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = mem_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = (QUEUE_AW+1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (QUEUE_AW+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/kbsc_back.sv
`default_nettype none

module kbsc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  kbsc_pkg::entry_type    head,
   input  kbsc_pkg::q_status_type q_status,
   output logic                   q_pop,
   input  wire                    rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_scan_byte,
   output logic                   rsp_last_byte
);
   import kbsc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic [1:0] step_ff, step_in;
   logic       out_free, emit;
   logic [7:0] byte_sel;
   logic       last_sel;

   always_comb begin
      unique case (head.kind)
         KIND_PAD: begin
            byte_sel = (step_ff == 2'd0) ? PAD_PREFIX : head.scan;
            last_sel = (step_ff == 2'd1);
         end
         KIND_SHIFT: begin
            if (step_ff == 2'd0) begin
               byte_sel = head.press ? SHIFT_MAKE : SHIFT_BREAK;
            end else if (step_ff == 2'd1) begin
               byte_sel = PAD_PREFIX;
            end else begin
               byte_sel = head.scan;
            end
            last_sel = (step_ff == 2'd2);
         end
         default: begin
            byte_sel = head.scan;
            last_sel = 1'b1;
         end
      endcase

      out_free = !out_valid_ff || rsp_pop;
      emit     = out_free && !q_status.empty;
      q_pop    = emit && last_sel;

      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      step_in      = step_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         out_last_in  = last_sel;
         step_in      = last_sel ? 2'd0 : 2'(step_ff + 1'b1);
      end

      rsp_empty     = !out_valid_ff;
      rsp_scan_byte = out_byte_ff;
      rsp_last_byte = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

### src/keycode_to_keyboard_scancode.sv
// Key event to legacy keyboard scan byte translator.
// Input channel: present req_key_code / req_key_action with req_push; the
// transaction is taken at a clock edge with req_push high and req_full low.
// Releases, presses and repeats are all taken at the input; repeats,
// unmapped codes and caps lock releases yield no bytes.
// Result channel: while rsp_empty is low, rsp_scan_byte / rsp_last_byte hold
// the oldest byte; it is taken at an edge with rsp_pop high.
// Path: the first byte of an event is written into the event queue and then
// into the output register before it shows on the result ports.
// Throughput: the front takes one event per cycle while its 4-entry event
// queue has room; the back sequencer emits one byte per cycle while the
// output register is empty or popped, and an event yields 1, 2 or 3 bytes
// (plain key, keypad/arrow key, keypad asterisk/plus/slash). Sustained rate
// is set by the back.
// Stall: with rsp_pop low the output register holds, the back stops and the
// queue fills; req_full rises once four events wait.
// Reset: clears the caps lock flag, the queue and the output register.
`default_nettype none

module keycode_to_keyboard_scancode (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_push,
   output logic       req_full,
   input  wire  [7:0] req_key_code,
   input  wire  [1:0] req_key_action,
   output logic       rsp_empty,
   input  wire        rsp_pop,
   output logic [7:0] rsp_scan_byte,
   output logic       rsp_last_byte
);
   import kbsc_pkg::*;

   q_status_type q_status;
   entry_type    q_entry, q_head;
   logic         q_push, q_pop;

   assign req_full = q_status.full;

   kbsc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_key_code   (req_key_code),
      .req_key_action (req_key_action),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   kbsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   kbsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_scan_byte (rsp_scan_byte),
      .rsp_last_byte (rsp_last_byte)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("event queue written while full");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("event queue popped while empty");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && q_status.empty))
      else $error("output or queue not empty after reset");
`endif

endmodule

`default_nettype wire

### bench/tb_keycode_to_keyboard_scancode.sv
`timescale 1ns / 100ps

module tb_keycode_to_keyboard_scancode;
   import kbsc_pkg::*;

   localparam logic [1:0] ACTION_PRESS     = 2'd1;
   localparam logic [1:0] ACTION_UNDEFINED = 2'd3;
   localparam int         EVENT_COUNT      = 400;
   localparam int         DRAIN_EVERY      = 100;
   localparam int         CYCLE_LIMIT      = 400000;

   // bit 8 valid, bits 7..0 make code; index 0 is leftmost
   localparam logic [0:127][8:0] KEY_SCAN = {
      9'h000, 9'h000, 9'h125, 9'h127, 9'h129, 9'h12b, 9'h12f, 9'h12d,
      9'h135, 9'h139, 9'h133, 9'h13b, 9'h137, 9'h131, 9'h167, 9'h161,
      9'h119, 9'h11b, 9'h11d, 9'h11f, 9'h123, 9'h121, 9'h141, 9'h145,
      9'h13f, 9'h147, 9'h143, 9'h13d, 9'h149, 9'h175, 9'h101, 9'h103,
      9'h105, 9'h107, 9'h10b, 9'h109, 9'h14d, 9'h151, 9'h14b, 9'h153,
      9'h14f, 9'h165, 9'h171, 9'h155, 9'h10d, 9'h10f, 9'h111, 9'h113,
      9'h117, 9'h15b, 9'h15d, 9'h157, 9'h15f, 9'h159, 9'h171, 9'h105,
      9'h16f, 9'h163, 9'h173, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h10f, 9'h000, 9'h133,
      9'h137, 9'h139, 9'h11d, 9'h12d, 9'h12f, 9'h131, 9'h10d, 9'h127,
      9'h129, 9'h12b, 9'h125, 9'h103, 9'h000, 9'h000, 9'h155, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h119, 9'h175, 9'h11b, 9'h000, 9'h16f, 9'h000, 9'h000, 9'h11b,
      9'h000, 9'h10d, 9'h105, 9'h000, 9'h111, 9'h000, 9'h000, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h16f, 9'h16f, 9'h16f
   };

   typedef struct {
      logic [7:0] code;
      logic [1:0] action;
      bit         drain_first;
   } key_event_t;

   typedef struct {
      logic [7:0] scan;
      logic       last;
   } scan_out_t;

   typedef enum logic [1:0] {
      POP_FREE,
      POP_COIN,
      POP_MASK,
      POP_SPARSE
   } pop_mode_t;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_push       = 1'b0;
   logic [7:0] req_key_code   = 8'd0;
   logic [1:0] req_key_action = 2'd0;
   logic       rsp_pop        = 1'b0;
   wire        req_full;
   wire        rsp_empty;
   wire  [7:0] rsp_scan_byte;
   wire        rsp_last_byte;

   key_event_t pending_events[$];
   scan_out_t  owed_bytes[$];
   bit         caps_on     = 1'b0;
   bit         push_taken  = 1'b0;
   int         mismatches  = 0;
   int         cycles      = 0;
   int         gap_left    = 0;
   int         burst_left  = 0;
   int         mode_left   = 0;
   int         sparse_wait = 0;
   logic [7:0] pop_mask    = 8'hff;
   pop_mode_t  pop_mode    = POP_FREE;

   keycode_to_keyboard_scancode dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_key_code   (req_key_code),
      .req_key_action (req_key_action),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_scan_byte  (rsp_scan_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit takes_pad_prefix(input logic [7:0] code);
      case (code)
         8'd69, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77,
         8'd79, 8'd80, 8'd81, 8'd82, 8'd83,
         8'd96, 8'd103, 8'd105, 8'd106, 8'd108: takes_pad_prefix = 1'b1;
         default: takes_pad_prefix = 1'b0;
      endcase
   endfunction

   function automatic logic [8:0] scan_entry(input logic [7:0] code);
      if (code < TABLE_ENTRIES && !code[7])
         scan_entry = KEY_SCAN[code[6:0]];
      else
         scan_entry = 9'd0;
   endfunction

   function automatic void owe_byte(input logic [7:0] scan, input logic last);
      scan_out_t b;
      b.scan = scan;
      b.last = last;
      owed_bytes.push_back(b);
   endfunction

   function automatic void translate_key_event(input logic [7:0] code,
                                               input logic [1:0] action);
      logic [8:0] entry;
      logic [7:0] keyed;
      logic       press;
      entry = scan_entry(code);
      if (action == ACTION_REPEAT || !entry[8])
         return;
      press = (action != ACTION_RELEASE);
      keyed = press ? entry[7:0] : (entry[7:0] | RELEASE_BIT);
      if (code == CODE_CAPS) begin
         if (press) begin
            caps_on = !caps_on;
            owe_byte(caps_on ? entry[7:0] : (entry[7:0] | RELEASE_BIT), 1'b1);
         end
      end else if (code == CODE_PAD_STAR || code == CODE_PAD_PLUS ||
                   code == CODE_PAD_SLASH) begin
         owe_byte(press ? SHIFT_MAKE : SHIFT_BREAK, 1'b0);
         owe_byte(PAD_PREFIX, 1'b0);
         owe_byte(keyed, 1'b1);
      end else if (takes_pad_prefix(code)) begin
         owe_byte(PAD_PREFIX, 1'b0);
         owe_byte(keyed, 1'b1);
      end else begin
         owe_byte(keyed, 1'b1);
      end
   endfunction

   function automatic void queue_event(input logic [7:0] code, input logic [1:0] action,
                                       input bit drain_first);
      key_event_t ev;
      ev.code        = code;
      ev.action      = action;
      ev.drain_first = drain_first;
      pending_events.push_back(ev);
   endfunction

   function automatic logic [7:0] pick_code();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0:       c = CODE_CAPS;
            1:       c = CODE_PAD_STAR;
            2:       c = CODE_PAD_PLUS;
            default: c = CODE_PAD_SLASH;
         endcase
      end else if (r < 32) begin
         do c = 8'($urandom_range(64, 127)); while (!takes_pad_prefix(c));
      end else if (r < 85) begin
         c = 8'($urandom_range(0, 127));
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      pick_code = c;
   endfunction

   function automatic logic [1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)      pick_action = ACTION_PRESS;
      else if (r < 75) pick_action = ACTION_RELEASE;
      else if (r < 88) pick_action = ACTION_UNDEFINED;
      else             pick_action = ACTION_REPEAT;
   endfunction

   // sender: bursts and gaps, holds each transaction until taken
   always @(negedge clock) begin
      key_event_t ev;
      int         r;
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !push_taken) begin
      end else if (gap_left != 0) begin
         gap_left--;
         req_push <= 1'b0;
      end else if (pending_events.size() != 0 &&
                   (!pending_events[0].drain_first || owed_bytes.size() == 0)) begin
         ev = pending_events.pop_front();
         req_push       <= 1'b1;
         req_key_code   <= ev.code;
         req_key_action <= ev.action;
         if (burst_left == 0) begin
            r = $urandom_range(0, 99);
            burst_left = (r < 20) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         end
         burst_left--;
         if (burst_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 35)      gap_left = 0;
            else if (r < 85) gap_left = $urandom_range(1, 6);
            else             gap_left = $urandom_range(7, 30);
         end
      end else begin
         req_push <= 1'b0;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pop_mode  = pop_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 160);
            pop_mask  = 8'($urandom_range(0, 255)) | 8'h01;
         end else begin
            mode_left--;
         end
         case (pop_mode)
            POP_FREE: rsp_pop <= 1'b1;
            POP_COIN: rsp_pop <= 1'($urandom_range(0, 1));
            POP_MASK: begin
               rsp_pop <= pop_mask[0];
               pop_mask = {pop_mask[0], pop_mask[7:1]};
            end
            default: begin
               if (sparse_wait == 0) begin
                  rsp_pop <= 1'b1;
                  sparse_wait = $urandom_range(2, 20);
               end else begin
                  rsp_pop <= 1'b0;
                  sparse_wait--;
               end
            end
         endcase
      end
   end

   // monitor: predict on input transaction, check on result transaction
   always @(posedge clock) begin
      scan_out_t want;
      push_taken = 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            push_taken = 1'b1;
            translate_key_event(req_key_code, req_key_action);
         end
         if (rsp_pop && !rsp_empty) begin
            if (owed_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual scan %h last %b",
                        $time, rsp_scan_byte, rsp_last_byte);
               mismatches++;
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_scan_byte !== want.scan) begin
                  $display("%0t: scan_byte mismatch: expected %h, actual %h",
                           $time, want.scan, rsp_scan_byte);
                  mismatches++;
               end
               if (rsp_last_byte !== want.last) begin
                  $display("%0t: last_byte mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last_byte);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int         counted;
      int         next_drain;
      logic [7:0] code;
      logic [1:0] action;
      bit         drain;

      queue_event(8'd2, ACTION_PRESS, 1'b0);
      queue_event(8'd2, ACTION_RELEASE, 1'b0);
      queue_event(8'd0, ACTION_PRESS, 1'b0);
      queue_event(8'd127, ACTION_PRESS, 1'b0);
      queue_event(8'd127, ACTION_RELEASE, 1'b0);
      queue_event(8'd128, ACTION_PRESS, 1'b0);
      queue_event(8'd255, ACTION_RELEASE, 1'b0);
      queue_event(CODE_CAPS, ACTION_PRESS, 1'b0);
      queue_event(CODE_CAPS, ACTION_RELEASE, 1'b0);
      queue_event(CODE_CAPS, ACTION_PRESS, 1'b0);
      queue_event(CODE_CAPS, ACTION_REPEAT, 1'b0);
      queue_event(CODE_CAPS, ACTION_UNDEFINED, 1'b0);
      queue_event(CODE_PAD_STAR, ACTION_PRESS, 1'b0);
      queue_event(CODE_PAD_STAR, ACTION_RELEASE, 1'b0);
      queue_event(CODE_PAD_PLUS, ACTION_PRESS, 1'b0);
      queue_event(CODE_PAD_SLASH, ACTION_RELEASE, 1'b0);
      queue_event(8'd69, ACTION_PRESS, 1'b0);
      queue_event(8'd108, ACTION_RELEASE, 1'b0);
      queue_event(8'd30, ACTION_UNDEFINED, 1'b0);
      queue_event(8'd30, ACTION_REPEAT, 1'b0);
      queue_event(8'd96, ACTION_UNDEFINED, 1'b0);
      queue_event(8'd86, ACTION_RELEASE, 1'b0);
      queue_event(8'd64, ACTION_PRESS, 1'b0);

      counted    = 0;
      next_drain = 0;
      while (counted < EVENT_COUNT) begin
         code   = pick_code();
         action = pick_action();
         drain  = (counted >= next_drain);
         if (drain)
            next_drain += DRAIN_EVERY;
         queue_event(code, action, drain);
         counted++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_events.size() != 0 || req_push || owed_bytes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
